// ===== rtl/stack_machine_executor_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine executor
// Shared concurrent assertion forms used by the controller module.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SME_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor package
// Shared constants, opcode and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int IMM_W       = 24;
    localparam int CNT_W       = $clog2(DATA_W + 1);

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSHC = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_RDINT = 8'd7;
    localparam logic [7:0] OP_WRINT = 8'd8;
    localparam logic [7:0] OP_RDCHR = 8'd9;
    localparam logic [7:0] OP_WRCHR = 8'd10;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_ILL   = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_CHR  = 2'd2;

    // Operation selected by the controller for the datapath.
    typedef enum logic [2:0] {
        DOP_PUSH = 3'd0,
        DOP_POP  = 3'd1,
        DOP_ADD  = 3'd2,
        DOP_SUB  = 3'd3,
        DOP_MUL  = 3'd4,
        DOP_DIV  = 3'd5,
        DOP_MOD  = 3'd6
    } dop_t;

    typedef struct packed {
        logic             fetch;     // read top and second entries
        logic             start;     // latch operands and begin operation
        logic             commit;    // write result, update stack pointer
        dop_t             op;
        logic [DATA_W-1:0] push_val;
    } dp_cmd_t;

    typedef struct packed {
        logic              done;     // result ready for commit
        logic              top_zero;
        logic [SP_W-1:0]   sp;
        logic [DATA_W-1:0] pop_val;
    } dp_stat_t;

endpackage

// ===== rtl/stack_machine_executor_core.sv =====
// Sequencing: each input transfer passes through the fetch and check states, then the run
// state for add, sub, mul, div and mod when no fault is found, then the done state, after
// which the result is presented; div and mod run the 32 steps of the one-bit-per-cycle divider.
// Throughput: one instruction at a time; the next input transfer can be taken in the cycle in
// which the result is first presented, and a stalled result holds the next one in the fetch state.
// Reset (aresetn low, synchronous) empties the stack, clears the halted flag and drops
// any pending result; stack entries themselves keep their contents.
// ----------------------------------------------------------------------------
// Stack machine executor core
// Executes one stack-machine instruction per input transfer and returns one
// status result per instruction on the master stream.
// ----------------------------------------------------------------------------
module stack_machine_executor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // cmd[7:0], immediate[31:8], read_value[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[2:0], out_kind[4:3], out_value[36:5],
                                  // depth[41:37], zero fill [47:42]
);

    // Controller and datapath exchange only command and status structs.
    sme_pkg::dp_cmd_t  dp_cmd;
    sme_pkg::dp_stat_t dp_stat;
    logic [2:0]                 status;
    logic [1:0]                 out_kind;
    logic [sme_pkg::DATA_W-1:0] out_value;
    logic [4:0]                 depth;

    sme_control u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[7:0]),
        .in_imm    (s_tdata[31:8]),
        .in_rdv    (s_tdata[63:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_status(status),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_depth (depth),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    sme_datapath u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (dp_cmd),
        .stat   (dp_stat)
    );

    // Result fields packed from the lowest bit up, zero filled to whole bytes.
    assign m_tdata = {6'b0, depth, out_value, out_kind, status};

endmodule

// ===== rtl/sme_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack machine datapath
// Operand stack memory, stack pointer, ALU, multiplier and serial divider.
// ----------------------------------------------------------------------------
module sme_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  sme_pkg::dp_cmd_t cmd,
    output sme_pkg::dp_stat_t stat
);

    logic [sme_pkg::DATA_W-1:0] mem [sme_pkg::STACK_DEPTH];
    logic [sme_pkg::SP_W-1:0]   sp_reg;
    logic [sme_pkg::DATA_W-1:0] top_reg, sec_reg;
    logic [sme_pkg::DATA_W-1:0] a_reg, b_reg, res_reg;
    logic [sme_pkg::DATA_W-1:0] q_reg, r_reg, dm_reg;
    logic                       neg_q_reg, neg_r_reg;
    logic [sme_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg, done_reg;
    sme_pkg::dop_t              op_reg;
    logic [sme_pkg::ADDR_W-1:0] a_top, a_sec, a_wr;
    logic [sme_pkg::DATA_W:0]   trial;
    logic [sme_pkg::DATA_W-1:0] r_shift;
    logic                       is_div;

    assign a_top = sme_pkg::ADDR_W'(sp_reg - sme_pkg::SP_W'(1));
    assign a_sec = sme_pkg::ADDR_W'(sp_reg - sme_pkg::SP_W'(2));
    assign a_wr  = (cmd.op == sme_pkg::DOP_PUSH) ? sme_pkg::ADDR_W'(sp_reg) : a_sec;
    assign is_div = (op_reg == sme_pkg::DOP_DIV) || (op_reg == sme_pkg::DOP_MOD);

    // One restoring division step per cycle.
    assign r_shift = {r_reg[sme_pkg::DATA_W-2:0], q_reg[sme_pkg::DATA_W-1]};
    assign trial   = {1'b0, r_shift} - {1'b0, dm_reg};

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            top_reg <= mem[a_top];
            sec_reg <= mem[a_sec];
        end
        if (cmd.commit && (cmd.op == sme_pkg::DOP_PUSH)) begin
            mem[a_wr] <= cmd.push_val;
        end else if (cmd.commit && (cmd.op != sme_pkg::DOP_POP)) begin
            mem[a_wr] <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.commit) begin
                unique case (cmd.op)
                    sme_pkg::DOP_PUSH: sp_reg <= sp_reg + sme_pkg::SP_W'(1);
                    default:           sp_reg <= sp_reg - sme_pkg::SP_W'(1);
                endcase
            end
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= sme_pkg::CNT_W'(sme_pkg::DATA_W);
            end else if (busy_reg) begin
                if (!is_div || cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - sme_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= cmd.op;
            a_reg     <= sec_reg;
            b_reg     <= top_reg;
            q_reg     <= sec_reg[sme_pkg::DATA_W-1] ? -sec_reg : sec_reg;
            dm_reg    <= top_reg[sme_pkg::DATA_W-1] ? -top_reg : top_reg;
            r_reg     <= '0;
            neg_q_reg <= sec_reg[sme_pkg::DATA_W-1] ^ top_reg[sme_pkg::DATA_W-1];
            neg_r_reg <= sec_reg[sme_pkg::DATA_W-1];
        end else if (busy_reg) begin
            if (is_div && cnt_reg != '0) begin
                if (!trial[sme_pkg::DATA_W]) begin
                    r_reg <= trial[sme_pkg::DATA_W-1:0];
                    q_reg <= {q_reg[sme_pkg::DATA_W-2:0], 1'b1};
                end else begin
                    r_reg <= r_shift;
                    q_reg <= {q_reg[sme_pkg::DATA_W-2:0], 1'b0};
                end
            end else begin
                case (op_reg)
                    sme_pkg::DOP_ADD: res_reg <= a_reg + b_reg;
                    sme_pkg::DOP_SUB: res_reg <= a_reg - b_reg;
                    sme_pkg::DOP_MUL: res_reg <= a_reg * b_reg;
                    sme_pkg::DOP_DIV: res_reg <= neg_q_reg ? -q_reg : q_reg;
                    default:          res_reg <= neg_r_reg ? -r_reg : r_reg;
                endcase
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.top_zero = (top_reg == '0);
    assign stat.sp       = sp_reg;
    assign stat.pop_val  = top_reg;

endmodule

// ===== rtl/sme_control.sv =====
// ----------------------------------------------------------------------------
// Stack machine controller
// Decodes one instruction, checks faults and sequences the datapath.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_core_assert.svh"

module sme_control (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_cmd,
    input  logic [sme_pkg::IMM_W-1:0]  in_imm,
    input  logic [sme_pkg::DATA_W-1:0] in_rdv,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 out_status,
    output logic [1:0]                 out_kind,
    output logic [sme_pkg::DATA_W-1:0] out_value,
    output logic [4:0]                 out_depth,
    output sme_pkg::dp_cmd_t           dp_cmd,
    input  sme_pkg::dp_stat_t          dp_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_CHECK = 5'b00100,
        S_RUN   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       halted_reg;
    logic [7:0]                 cmd_reg;
    logic [sme_pkg::DATA_W-1:0] pval_reg;
    logic                       ovalid_reg;
    logic [2:0]                 ostat_reg;
    logic [1:0]                 okind_reg;
    logic [sme_pkg::DATA_W-1:0] oval_reg;
    logic [4:0]                 odepth_reg;
    sme_pkg::dop_t              op;
    logic                       is_push, is_pop, is_bin;

    assign is_push = (cmd_reg == sme_pkg::OP_PUSHC) || (cmd_reg == sme_pkg::OP_RDINT)
                  || (cmd_reg == sme_pkg::OP_RDCHR);
    assign is_pop  = (cmd_reg == sme_pkg::OP_WRINT) || (cmd_reg == sme_pkg::OP_WRCHR);
    assign is_bin  = !is_push && !is_pop && (cmd_reg != sme_pkg::OP_HALT);

    always_comb begin
        unique case (cmd_reg) inside
            sme_pkg::OP_ADD: op = sme_pkg::DOP_ADD;
            sme_pkg::OP_SUB: op = sme_pkg::DOP_SUB;
            sme_pkg::OP_MUL: op = sme_pkg::DOP_MUL;
            sme_pkg::OP_DIV: op = sme_pkg::DOP_DIV;
            sme_pkg::OP_MOD: op = sme_pkg::DOP_MOD;
            sme_pkg::OP_WRINT, sme_pkg::OP_WRCHR: op = sme_pkg::DOP_POP;
            default:         op = sme_pkg::DOP_PUSH;
        endcase
    end

    // A new instruction may be taken while the previous result still waits.
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && in_ready) state_next = S_FETCH;
            // The result registers are rewritten in the check state, so the
            // instruction waits here until the previous result has left.
            S_FETCH: if (!ovalid_reg || out_ready) state_next = S_CHECK;
            S_CHECK: begin
                if (!halted_reg && cmd_reg <= sme_pkg::OP_WRCHR && is_bin
                    && dp_stat.sp >= sme_pkg::SP_W'(2)
                    && !((op == sme_pkg::DOP_DIV || op == sme_pkg::DOP_MOD)
                         && dp_stat.top_zero)) begin
                    state_next = S_RUN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RUN:   if (dp_stat.done) state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd          = '0;
        dp_cmd.op       = op;
        dp_cmd.push_val = pval_reg;
        dp_cmd.fetch    = (state_reg == S_FETCH);
        dp_cmd.start    = (state_reg == S_CHECK) && (state_next == S_RUN);
        if (state_reg == S_CHECK && !halted_reg && cmd_reg <= sme_pkg::OP_WRCHR) begin
            if (is_push && dp_stat.sp < sme_pkg::SP_W'(sme_pkg::STACK_DEPTH)) begin
                dp_cmd.commit = 1'b1;
            end
            if (is_pop && dp_stat.sp != '0) begin
                dp_cmd.commit = 1'b1;
            end
        end
        if (state_reg == S_RUN && dp_stat.done) begin
            dp_cmd.commit = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            halted_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid && out_ready) begin
                ovalid_reg <= 1'b0;
            end
            if (state_reg == S_CHECK && !halted_reg && cmd_reg == sme_pkg::OP_HALT) begin
                halted_reg <= 1'b1;
            end
            if (state_reg == S_DONE) begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            cmd_reg <= in_cmd;
            case (in_cmd)
                sme_pkg::OP_PUSHC: pval_reg <= sme_pkg::DATA_W'(in_imm);
                sme_pkg::OP_RDCHR: pval_reg <= sme_pkg::DATA_W'(in_rdv[7:0]);
                default:           pval_reg <= in_rdv;
            endcase
        end
        if (state_reg == S_CHECK) begin
            ostat_reg <= sme_pkg::ST_OK;
            okind_reg <= sme_pkg::KIND_NONE;
            oval_reg  <= '0;
            if (halted_reg) begin
                ostat_reg <= sme_pkg::ST_HALT;
            end else if (cmd_reg > sme_pkg::OP_WRCHR) begin
                ostat_reg <= sme_pkg::ST_ILL;
            end else if (is_push) begin
                if (dp_stat.sp >= sme_pkg::SP_W'(sme_pkg::STACK_DEPTH)) begin
                    ostat_reg <= sme_pkg::ST_OVER;
                end
            end else if (is_pop) begin
                if (dp_stat.sp == '0) begin
                    ostat_reg <= sme_pkg::ST_UNDER;
                end else if (cmd_reg == sme_pkg::OP_WRINT) begin
                    okind_reg <= sme_pkg::KIND_INT;
                    oval_reg  <= dp_stat.pop_val;
                end else begin
                    okind_reg <= sme_pkg::KIND_CHR;
                    oval_reg  <= sme_pkg::DATA_W'(dp_stat.pop_val[7:0]);
                end
            end else if (is_bin) begin
                if (dp_stat.sp < sme_pkg::SP_W'(2)) begin
                    ostat_reg <= sme_pkg::ST_UNDER;
                end else if ((op == sme_pkg::DOP_DIV || op == sme_pkg::DOP_MOD)
                             && dp_stat.top_zero) begin
                    ostat_reg <= sme_pkg::ST_DIV0;
                end
            end
        end
        if (state_reg == S_DONE) begin
            odepth_reg <= 5'(dp_stat.sp);
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_kind   = okind_reg;
    assign out_value  = oval_reg;
    assign out_depth  = odepth_reg;

    `SME_ASSERT_IMP(a_one_hot, aclk, aresetn, 1'b1, $onehot(state_reg), "state not one-hot")
    `SME_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !in_ready,
                    "input accepted while busy")
    `SME_ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == S_DONE, out_valid,
                     "result not presented after completion")

endmodule
